[src/lwev_pkg.sv]
// ----------------------------------------------------------------------------
// lwev_pkg
// shared types and constants for the log-law wall viscosity block
// ----------------------------------------------------------------------------
`default_nettype none
package lwev_pkg;

  localparam int unsigned W = 64;
  localparam int unsigned MAX_NEWTON_STEPS = 10;
  localparam int unsigned STEP_W = $clog2(MAX_NEWTON_STEPS + 1);

  localparam logic [W-1:0] Q_ONE     = 64'd1 << 40;
  localparam logic [W-1:0] Q_MAX     = {W{1'b1}};
  localparam logic [W-1:0] KU_CLAMP  = 64'd50 << 40;
  localparam logic [W-1:0] ERR_LIMIT = 64'd10995116277;
  localparam logic [W-1:0] LN2_Q64   = 64'hB17217F7D1CF79AC;

  localparam logic [W-1:0] KAPPA_RST = 64'd450799767388;
  localparam logic [W-1:0] E_RST     = 64'd10775215952205;
  localparam logic [W-1:0] YLIM_RST  = 64'd12677369068257;

  localparam logic [1:0] REG_KAPPA = 2'd0;
  localparam logic [1:0] REG_E     = 2'd1;
  localparam logic [1:0] REG_YLIM  = 2'd2;

  localparam logic [1:0] REGIME_LAMINAR = 2'd0;
  localparam logic [1:0] REGIME_TINY    = 2'd1;
  localparam logic [1:0] REGIME_LOGLAW  = 2'd2;

  // operations of the shared unit
  typedef enum logic [2:0] {
    OP_MUL,
    OP_DIV,
    OP_SQRT,
    OP_LN
  } op_e;

  typedef struct packed {
    logic          start;
    op_e           op;
    logic [W-1:0]  a;
    logic [W-1:0]  b;
  } alu_req_t;

  typedef struct packed {
    logic          done;
    logic [W-1:0]  res;
  } alu_rsp_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_SUM,
    S_MUL1,
    S_SQRT,
    S_MUL2,
    S_DIV_Y,
    S_CLASS,
    S_KU,
    S_EY,
    S_LN,
    S_KUDIV,
    S_QDIV,
    S_ERRDIV,
    S_UPD,
    S_SQ,
    S_VDIV,
    S_OUT
  } state_e;

endpackage
`default_nettype wire

[src/loglaw_wall_eddy_viscosity.sv]
// the result is computed step by step through the shared alu;
// divide and sqrt run bit-serially (a saturating divide ends early), multiply and log iterate
// one item at a time: in_ready_o is high only while the sequencer is idle
// reset: async active low, registers return to kappa 0.41, E 9.8, y+ limit 11.53
// ----------------------------------------------------------------------------
// loglaw_wall_eddy_viscosity
// log-law wall function for the face subgrid viscosity, Newton refined u_tau
// ----------------------------------------------------------------------------
`default_nettype none
module loglaw_wall_eddy_viscosity (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [63:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [63:0] parallel_speed_i,
  input  wire logic [63:0] subgrid_visc_prev_i,
  input  wire logic [63:0] molecular_visc_i,
  input  wire logic [63:0] wall_gradient_i,
  input  wire logic [63:0] inverse_wall_distance_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [63:0]      subgrid_visc_new_o,
  output logic [1:0]       regime_o,
  output logic [3:0]       iterations_used_o
);
  import lwev_pkg::*;

  state_e st_q, st_d;
  logic [W-1:0] kappa_q, e_q, ylim_q;
  logic [W-1:0] upar_q, nusgs_q, nu_q, grad_q, ry_q;
  logic [W-1:0] t_q, t_d, utau_q, utau_d, yplus_q, yplus_d, kuraw_q, kuraw_d;
  logic [W-1:0] lg_q, lg_d, ku_q, ku_d, qmag_q, qmag_d, fmag;
  logic         fneg_q, fneg_d;
  logic [STEP_W-1:0] steps_q, steps_d;
  logic [W-1:0] visc_q, visc_d;
  logic [1:0]   regime_q, regime_d;
  logic         issued_q, issued_d;
  logic         ovalid_q, ovalid_d;
  alu_req_t     req;
  alu_rsp_t     rsp;
  logic [W:0]   sum;
  logic signed [W:0] f;

  lwev_alu u_alu (.clk_i, .rst_ni, .req_i(req), .rsp_o(rsp));

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (st_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kappa_q <= KAPPA_RST; e_q <= E_RST; ylim_q <= YLIM_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_KAPPA: kappa_q <= cfg_data_i;
        REG_E:     e_q <= cfg_data_i;
        REG_YLIM:  ylim_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    st_d = st_q; t_d = t_q; utau_d = utau_q; yplus_d = yplus_q; kuraw_d = kuraw_q;
    lg_d = lg_q; ku_d = ku_q; qmag_d = qmag_q; fneg_d = fneg_q; steps_d = steps_q;
    visc_d = visc_q; regime_d = regime_q; issued_d = issued_q; ovalid_d = ovalid_q;
    req = '{start: 1'b0, op: OP_MUL, a: '0, b: '0};
    sum = '0; f = '0; fmag = '0;
    case (st_q)
      S_IDLE: if (in_valid_i) begin st_d = S_SUM; steps_d = '0; visc_d = '0; end
      S_SUM: begin
        sum = {1'b0, nusgs_q} + {1'b0, nu_q};
        t_d = sum[W] ? Q_MAX : sum[W-1:0];
        st_d = S_MUL1; issued_d = 1'b0;
      end
      default: ;
    endcase
    // alu driven states: issue once, wait for done
    if (st_q inside {S_MUL1, S_SQRT, S_MUL2, S_DIV_Y, S_KU, S_EY, S_LN, S_KUDIV,
                     S_QDIV, S_ERRDIV, S_SQ, S_VDIV}) begin
      req.start = !issued_q;
      issued_d = 1'b1;
      case (st_q)
        S_MUL1:   begin req.op = OP_MUL;  req.a = t_q;     req.b = grad_q; end
        S_SQRT:   begin req.op = OP_SQRT; req.a = t_q;     end
        S_MUL2:   begin req.op = OP_MUL;  req.a = nu_q;    req.b = ry_q; end
        S_DIV_Y:  begin req.op = OP_DIV;  req.a = utau_q;  req.b = t_q; end
        S_KU:     begin req.op = OP_MUL;  req.a = kappa_q; req.b = upar_q; end
        S_EY:     begin req.op = OP_MUL;  req.a = e_q;     req.b = yplus_q; end
        S_LN:     begin req.op = OP_LN;   req.a = t_q;     end
        S_KUDIV:  begin req.op = OP_DIV;  req.a = kuraw_q; req.b = utau_q; end
        S_QDIV:   begin req.op = OP_DIV;  req.a = t_q;     req.b = ku_q + Q_ONE; end
        S_ERRDIV: begin req.op = OP_DIV;  req.a = qmag_q;  req.b = utau_q; end
        S_SQ:     begin req.op = OP_MUL;  req.a = utau_q;  req.b = utau_q; end
        S_VDIV:   begin req.op = OP_DIV;  req.a = t_q;     req.b = grad_q; end
        default: ;
      endcase
      if (rsp.done && issued_q) begin
        issued_d = 1'b0;
        case (st_q)
          S_MUL1:  begin t_d = rsp.res; st_d = S_SQRT; end
          S_SQRT:  begin utau_d = rsp.res; st_d = S_MUL2; end
          S_MUL2:  begin t_d = rsp.res; st_d = S_DIV_Y; end
          S_DIV_Y: begin yplus_d = rsp.res; st_d = S_CLASS; end
          S_KU:    begin kuraw_d = rsp.res; st_d = S_EY; end
          S_EY:    begin t_d = rsp.res; st_d = S_LN; end
          S_LN:    begin lg_d = rsp.res; st_d = S_KUDIV; end
          S_KUDIV: begin
            ku_d = (rsp.res > KU_CLAMP) ? KU_CLAMP : rsp.res;
            f = signed'({1'b0, ku_d}) - signed'({lg_q[W-1], lg_q});
            fneg_d = f[W];
            fmag = f[W] ? W'(-f) : W'(f);
            t_d = fmag; st_d = S_QDIV;
          end
          S_QDIV:  begin qmag_d = rsp.res; st_d = S_ERRDIV; end
          S_ERRDIV: begin
            t_d = rsp.res; st_d = S_UPD;
          end
          S_SQ:    begin t_d = rsp.res; st_d = S_VDIV; end
          S_VDIV:  begin
            visc_d = (rsp.res > nu_q) ? rsp.res - nu_q : '0;
            st_d = S_OUT; ovalid_d = 1'b1;
          end
          default: ;
        endcase
      end
    end
    case (st_q)
      S_CLASS: begin
        if (yplus_q <= ylim_q) begin
          regime_d = REGIME_LAMINAR; st_d = S_OUT; ovalid_d = 1'b1;
        end else if (utau_q <= 64'd1) begin
          regime_d = REGIME_TINY; st_d = S_OUT; ovalid_d = 1'b1;
        end else begin
          regime_d = REGIME_LOGLAW; st_d = S_KU;
        end
      end
      S_UPD: begin
        sum = {1'b0, utau_q} + {1'b0, qmag_q};
        if (!fneg_q) utau_d = sum[W] ? Q_MAX : sum[W-1:0];
        else if (qmag_q >= utau_q) utau_d = '0;
        else utau_d = utau_q - qmag_q;
        steps_d = steps_q + STEP_W'(1);
        if (utau_d <= 64'd1 || t_q <= ERR_LIMIT ||
            steps_d >= STEP_W'(MAX_NEWTON_STEPS)) st_d = S_SQ;
        else st_d = S_KUDIV;
      end
      S_OUT: if (out_ready_i) begin ovalid_d = 1'b0; st_d = S_IDLE; end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE; issued_q <= 1'b0; ovalid_q <= 1'b0;
    end else begin
      st_q <= st_d; issued_q <= issued_d; ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      upar_q <= parallel_speed_i; nusgs_q <= subgrid_visc_prev_i;
      nu_q <= molecular_visc_i; grad_q <= wall_gradient_i;
      ry_q <= inverse_wall_distance_i;
    end
    t_q <= t_d; utau_q <= utau_d; yplus_q <= yplus_d; kuraw_q <= kuraw_d;
    lg_q <= lg_d; ku_q <= ku_d; qmag_q <= qmag_d; fneg_q <= fneg_d;
    steps_q <= steps_d; visc_q <= visc_d; regime_q <= regime_d;
  end

  assign out_valid_o        = ovalid_q;
  assign subgrid_visc_new_o = visc_q;
  assign regime_o           = regime_q;
  assign iterations_used_o  = 4'(steps_q);

  a_out_in_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> st_q == S_OUT) else $error("result valid outside output state");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o) else $error("input ready while result pending");
  a_steps_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && regime_o != REGIME_LOGLAW) |-> iterations_used_o == 4'd0)
    else $error("steps reported outside log-law regime");

endmodule
`default_nettype wire

[src/lwev_alu.sv]
// ----------------------------------------------------------------------------
// lwev_alu
// shared multi-cycle unit: saturating q multiply, q divide, q sqrt and q ln
// ----------------------------------------------------------------------------
`default_nettype none
module lwev_alu (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire lwev_pkg::alu_req_t req_i,
  output lwev_pkg::alu_rsp_t      rsp_o
);
  import lwev_pkg::*;

  typedef enum logic [2:0] {
    A_IDLE, A_MUL, A_DIV, A_SQRT, A_LNNORM, A_LNSQ, A_LNMUL, A_DONE
  } astate_e;

  astate_e     st_q, st_d;
  op_e         op_q, op_d;
  logic [W-1:0] a_q, a_d, b_q, b_d;
  logic [W-1:0] r_q, r_d;       // remainder / work
  logic [W-1:0] q_q, q_d;       // quotient / root / frac
  logic [W-1:0] nlo_q, nlo_d;
  logic [6:0]   cnt_q, cnt_d;
  logic [W-1:0] res_q, res_d;
  logic [6:0]   lnexp_q, lnexp_d;
  logic [1:0]   mph_q, mph_d;   // multiply partial product phase
  logic [127:0] acc_q, acc_d;

  logic [127:0] pp;
  logic [31:0]  ma, mb;
  logic [6:0]   ppsh;
  logic         top;
  logic [W-1:0] rsh;
  logic [W+1:0] rem2, trial;
  logic [1:0]   two;
  logic [127:0] sqm;
  logic [W-1:0] sq;
  logic [6:0]   msb;
  logic signed [W-1:0] total;
  logic [W-1:0] mag;

  // one 32x32 partial product per cycle for 64x64 multiplies
  always_comb begin
    ma = mph_q[0] ? a_q[63:32] : a_q[31:0];
    mb = mph_q[1] ? b_q[63:32] : b_q[31:0];
    ppsh = {1'b0, mph_q[0], 5'd0} + {1'b0, mph_q[1], 5'd0};
    pp = {64'd0, 32'd0, 32'd0} | (128'(64'(ma) * 64'(mb)) << ppsh);
  end

  always_comb begin
    msb = 7'd0;
    for (int i = 0; i < W; i++) if (a_q[i]) msb = 7'(i);
  end

  always_comb begin
    st_d = st_q; op_d = op_q; a_d = a_q; b_d = b_q; r_d = r_q; q_d = q_q;
    nlo_d = nlo_q; cnt_d = cnt_q; res_d = res_q; lnexp_d = lnexp_q;
    mph_d = mph_q; acc_d = acc_q;
    top = 1'b0; rsh = '0; rem2 = '0; trial = '0; two = '0;
    sqm = acc_q; sq = '0; total = '0; mag = '0;
    case (st_q)
      A_IDLE: begin
        if (req_i.start) begin
          op_d = req_i.op; a_d = req_i.a; b_d = req_i.b;
          mph_d = '0; acc_d = '0; cnt_d = '0; q_d = '0;
          case (req_i.op)
            OP_MUL: st_d = A_MUL;
            OP_DIV: begin
              r_d = req_i.a >> 24; nlo_d = req_i.a << 40; cnt_d = 7'd64;
              if (req_i.b == '0) begin
                res_d = (req_i.a != '0) ? Q_MAX : '0; st_d = A_DONE;
              end else if ((req_i.a >> 24) >= req_i.b) begin
                res_d = Q_MAX; st_d = A_DONE;
              end else st_d = A_DIV;
            end
            OP_SQRT: begin
              r_d = '0; cnt_d = 7'd52; st_d = A_SQRT;
              nlo_d = req_i.a;
            end
            OP_LN: begin
              if (req_i.a == '0) a_d = 64'd1;
              st_d = A_LNNORM;
            end
            default: st_d = A_IDLE;
          endcase
        end
      end
      A_MUL: begin
        acc_d = acc_q + pp;
        mph_d = mph_q + 2'd1;
        if (mph_q == 2'd3) begin
          if (op_q == OP_MUL) begin
            res_d = ((acc_q + pp) >> 104) != '0 ? Q_MAX : W'((acc_q + pp) >> 40);
            st_d = A_DONE;
          end else st_d = A_LNMUL;
        end
      end
      A_DIV: begin
        top = r_q[W-1];
        rsh = {r_q[W-2:0], nlo_q[W-1]};
        nlo_d = nlo_q << 1;
        if (top || rsh >= b_q) begin
          r_d = rsh - b_q; q_d = {q_q[W-2:0], 1'b1};
        end else begin
          r_d = rsh; q_d = {q_q[W-2:0], 1'b0};
        end
        cnt_d = cnt_q - 7'd1;
        if (cnt_q == 7'd1) begin res_d = q_d; st_d = A_DONE; end
      end
      A_SQRT: begin
        // radicand is a*2^40; digit pairs from a, then zeros
        two = (cnt_q > 7'd20) ? 2'(a_q >> (2 * (cnt_q - 7'd1) - 7'd40)) : 2'd0;
        rem2 = {r_q, two};
        trial = {q_q, 2'b01};
        if (rem2 >= trial) begin
          r_d = W'(rem2 - trial); q_d = {q_q[W-2:0], 1'b1};
        end else begin
          r_d = W'(rem2); q_d = {q_q[W-2:0], 1'b0};
        end
        cnt_d = cnt_q - 7'd1;
        if (cnt_q == 7'd1) begin res_d = q_d; st_d = A_DONE; end
      end
      A_LNNORM: begin
        lnexp_d = msb;
        r_d = (msb <= 7'd62) ? (a_q << (7'd62 - msb)) : (a_q >> 1);
        cnt_d = 7'd40; q_d = '0;
        acc_d = '0; st_d = A_LNSQ; mph_d = '0;
        a_d = (msb <= 7'd62) ? (a_q << (7'd62 - msb)) : (a_q >> 1);
        b_d = a_d;
      end
      A_LNSQ: begin
        // squaring via four partial products accumulated in acc
        acc_d = acc_q + pp;
        mph_d = mph_q + 2'd1;
        if (mph_q == 2'd3) begin
          sqm = acc_q + pp;
          sq = sqm[125:62];
          if (sq[W-1]) begin
            a_d = sq >> 1; q_d = {q_q[W-2:0], 1'b1};
          end else begin
            a_d = sq; q_d = {q_q[W-2:0], 1'b0};
          end
          b_d = a_d; acc_d = '0;
          cnt_d = cnt_q - 7'd1;
          if (cnt_q == 7'd1) begin
            total = (signed'(W'(lnexp_q)) - 64'sd40) * signed'(Q_ONE) + signed'(q_d);
            mag = total[W-1] ? W'(-total) : W'(total);
            nlo_d = {63'd0, total[W-1]};
            a_d = mag; b_d = LN2_Q64;
            st_d = A_MUL;
          end
        end
      end
      A_LNMUL: begin
        // acc holds mag*ln2 from the multiply phase
        res_d = nlo_q[0] ? W'(-acc_q[127:64]) : acc_q[127:64];
        st_d = A_DONE;
      end
      A_DONE: st_d = A_IDLE;
      default: st_d = A_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= A_IDLE; mph_q <= '0; cnt_q <= '0;
    end else begin
      st_q <= st_d; mph_q <= mph_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d; a_q <= a_d; b_q <= b_d; r_q <= r_d; q_q <= q_d;
    nlo_q <= nlo_d; res_q <= res_d; lnexp_q <= lnexp_d; acc_q <= acc_d;
  end

  assign rsp_o.done = (st_q == A_DONE);
  assign rsp_o.res  = res_q;

endmodule
`default_nettype wire

[dv/loglaw_wall_eddy_viscosity_test.sv]
// ----------------------------------------------------------------------------
// loglaw_wall_eddy_viscosity_test
// Self-checking bench for the log-law wall viscosity block. A bit-exact
// Q24.40 predictor computes each face result. A scoreboard compares the
// block's results with it in order. Random handshake stalls run on both
// sides, and the registers are rewritten between phases.
// ----------------------------------------------------------------------------
module loglaw_wall_eddy_viscosity_test;
  timeunit 1ns;
  timeprecision 1ps;
  import lwev_pkg::*;

  typedef logic [63:0] q_t;

  typedef struct {
    q_t upar;
    q_t nusgs;
    q_t nu;
    q_t grad;
    q_t ry;
  } face_t;

  typedef struct {
    q_t         visc;
    logic [1:0] regime;
    logic [3:0] iters;
  } wall_res_t;

  // ---------------------------------------------------------------------------
  // fixed-point predictor
  // ---------------------------------------------------------------------------
  function automatic q_t sat_add(q_t a, q_t b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? Q_MAX : s[63:0];
  endfunction

  function automatic q_t fx_mul(q_t a, q_t b);
    logic [127:0] p;
    p = ({64'b0, a} * {64'b0, b}) >> 40;
    return (p[127:64] != 0) ? Q_MAX : p[63:0];
  endfunction

  function automatic q_t fx_div(q_t a, q_t b);
    logic [127:0] n, q;
    if (b == 0) return (a != 0) ? Q_MAX : 64'd0;
    n = {64'b0, a} << 40;
    q = n / {64'b0, b};
    return (q[127:64] != 0) ? Q_MAX : q[63:0];
  endfunction

  function automatic q_t fx_sqrt(q_t a);
    logic [127:0] n, t;
    n = {64'b0, a} << 40;
    t = 0;
    for (int b = 52; b >= 0; b--) begin
      logic [127:0] c;
      c = t | (128'd1 << b);
      if (c * c <= n) t = c;
    end
    return t[63:0];
  endfunction

  function automatic longint fx_ln(q_t x);
    int           p;
    q_t           m, frac, mag, hi;
    logic [127:0] sq, prod;
    longint       tot;
    if (x == 0) x = 64'd1;
    p = 63;
    while (!x[p]) p--;
    m = (p <= 62) ? (x << (62 - p)) : (x >> 1);
    frac = 0;
    for (int i = 0; i < 40; i++) begin
      sq = {64'b0, m} * {64'b0, m};
      if (sq[125]) begin
        m = {1'b0, sq[125:63]};
        frac = (frac << 1) | 64'd1;
      end else begin
        m = sq[125:62];
        frac = frac << 1;
      end
    end
    tot = (longint'(p) - 64'sd40) * 64'sd1099511627776 + longint'(frac);
    mag = (tot < 0) ? q_t'(-tot) : q_t'(tot);
    prod = {64'b0, mag} * {64'b0, LN2_Q64};
    hi = prod[127:64];
    return (tot < 0) ? -longint'(hi) : longint'(hi);
  endfunction

  class wall_scoreboard;
    q_t        kappa, e_off, ylim;
    wall_res_t pending[$];
    int        mismatches, failures;

    function new();
      kappa = KAPPA_RST;
      e_off = E_RST;
      ylim  = YLIM_RST;
    endfunction

    function void write_reg(logic [1:0] idx, q_t val);
      case (idx)
        REG_KAPPA: kappa = val;
        REG_E:     e_off = val;
        REG_YLIM:  ylim  = val;
        default: ;
      endcase
    endfunction

    function wall_res_t wall_law(face_t f);
      wall_res_t r;
      q_t        ut, yp, kuraw, ku, fmag, qmag, err, t;
      longint    lg, res;
      int        steps;
      r.visc = 0;
      steps = 0;
      ut = fx_sqrt(fx_mul(sat_add(f.nusgs, f.nu), f.grad));
      yp = fx_div(ut, fx_mul(f.nu, f.ry));
      if (yp <= ylim) begin
        r.regime = REGIME_LAMINAR;
      end else if (ut <= 64'd1) begin
        r.regime = REGIME_TINY;
      end else begin
        r.regime = REGIME_LOGLAW;
        kuraw = fx_mul(kappa, f.upar);
        lg = fx_ln(fx_mul(e_off, yp));
        forever begin
          ku = fx_div(kuraw, ut);
          if (ku > KU_CLAMP) ku = KU_CLAMP;
          res = longint'(ku) - lg;
          fmag = (res < 0) ? q_t'(-res) : q_t'(res);
          qmag = fx_div(fmag, ku + Q_ONE);
          err = fx_div(qmag, ut);
          if (res >= 0) ut = sat_add(ut, qmag);
          else if (qmag >= ut) ut = 0;
          else ut = ut - qmag;
          steps++;
          if (ut <= 64'd1 || err <= ERR_LIMIT || steps >= MAX_NEWTON_STEPS) break;
        end
        t = fx_div(fx_mul(ut, ut), f.grad);
        r.visc = (t > f.nu) ? t - f.nu : 64'd0;
      end
      r.iters = steps[3:0];
      return r;
    endfunction

    function void note_face(face_t f);
      pending.push_back(wall_law(f));
    endfunction

    function void check_result(q_t visc, logic [1:0] regime, logic [3:0] iters);
      wall_res_t w;
      if (pending.size() == 0) begin
        failures++;
        $display("unexpected result visc=%h regime=%0d iters=%0d", visc, regime, iters);
        return;
      end
      w = pending.pop_front();
      if (w.visc !== visc || w.regime !== regime || w.iters !== iters) begin
        mismatches++;
        failures++;
        if (mismatches <= 10)
          $display("mismatch: exp visc=%h regime=%0d iters=%0d, got visc=%h regime=%0d iters=%0d",
                   w.visc, w.regime, w.iters, visc, regime, iters);
      end
    endfunction
  endclass

  // ---------------------------------------------------------------------------
  // block and clocking
  // ---------------------------------------------------------------------------
  logic       clk_i, rst_ni;
  logic       cfg_valid_i, cfg_ready_o;
  logic [1:0] cfg_index_i;
  q_t         cfg_data_i;
  logic       in_valid_i, in_ready_o;
  q_t         parallel_speed_i, subgrid_visc_prev_i, molecular_visc_i;
  q_t         wall_gradient_i, inverse_wall_distance_i;
  logic       out_valid_o, out_ready_i;
  q_t         subgrid_visc_new_o;
  logic [1:0] regime_o;
  logic [3:0] iterations_used_o;

  loglaw_wall_eddy_viscosity dut (.*);

  wall_scoreboard sb = new();
  bit             calm;

  initial begin
    clk_i = 0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #200ms;
    $display("Regression FAIL");
    $finish;
  end

  always @(posedge clk_i)
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_result(subgrid_visc_new_o, regime_o, iterations_used_o);

  // result-side stalls
  initial begin
    out_ready_i = 0;
    @(posedge rst_ni);
    forever begin
      out_ready_i <= 1'b1;
      repeat ($urandom_range(1, 40)) @(posedge clk_i);
      if (!calm && $urandom_range(0, 1)) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk_i);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  function automatic q_t rnd64();
    return {$urandom, $urandom};
  endfunction

  // random value with its top bit between lo and hi
  function automatic q_t rnd_mag(int lo, int hi);
    int pos;
    pos = $urandom_range(lo, hi);
    return (rnd64() >> (63 - pos)) | (q_t'(1) << pos);
  endfunction

  task automatic send_face(face_t f);
    if (!calm && $urandom_range(0, 2) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    parallel_speed_i <= f.upar;
    subgrid_visc_prev_i <= f.nusgs;
    molecular_visc_i <= f.nu;
    wall_gradient_i <= f.grad;
    inverse_wall_distance_i <= f.ry;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_face(f);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, q_t val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.write_reg(idx, val);
    @(posedge clk_i);
  endtask

  function automatic face_t wall_face();
    face_t f;
    f.upar  = rnd_mag(30, 50);
    f.nusgs = ($urandom_range(0, 5) == 0) ? 64'd0 : rnd_mag(14, 34);
    f.nu    = rnd_mag(14, 32);
    f.grad  = rnd_mag(40, 58);
    f.ry    = rnd_mag(38, 54);
    return f;
  endfunction

  function automatic face_t noise_face();
    face_t f;
    f.upar  = rnd64();
    f.nusgs = rnd64();
    f.nu    = rnd64() >> $urandom_range(0, 63);
    f.grad  = rnd64() >> $urandom_range(0, 63);
    f.ry    = rnd64() >> $urandom_range(0, 63);
    return f;
  endfunction

  task automatic random_faces(int n);
    for (int i = 0; i < n; i++)
      send_face(($urandom_range(0, 4) == 0) ? noise_face() : wall_face());
  endtask

  initial begin
    face_t f;
    calm = 0;
    rst_ni = 0;
    cfg_valid_i = 0;
    cfg_index_i = 0;
    cfg_data_i = 0;
    in_valid_i = 0;
    parallel_speed_i = 0;
    subgrid_visc_prev_i = 0;
    molecular_visc_i = 0;
    wall_gradient_i = 0;
    inverse_wall_distance_i = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed faces at reset settings
    f = '{0, 0, 0, 0, 0};                         send_face(f);
    f = '{Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX};     send_face(f);
    f = '{Q_ONE, 0, Q_ONE, Q_ONE, 0};             send_face(f);  // zero divisor
    f = '{Q_ONE, Q_ONE, 0, Q_ONE, Q_ONE};         send_face(f);
    f = '{64'd1 << 44, 64'd1 << 20, 64'd1 << 20, 64'd1 << 52, 64'd1 << 46}; send_face(f);
    f = '{Q_MAX, 0, 64'd1 << 18, 64'd1 << 56, 64'd1 << 50}; send_face(f);  // clamped k*U+
    f = '{0, 0, 64'd1 << 18, 64'd1 << 56, 64'd1 << 50};     send_face(f);  // u_tau driven down
    f = '{64'd1, Q_MAX, 64'd1, Q_MAX, 64'd1};     send_face(f);
    f = '{64'd1 << 40, 0, 64'd1, 64'd1, 64'd1};   send_face(f);
    for (int i = 0; i < 6; i++) send_face(wall_face());
    random_faces(70);
    drain();

    // unknown index is dropped
    write_reg(2'd3, rnd64());
    write_reg(REG_KAPPA, Q_MAX);
    write_reg(REG_E, 0);                          // log of zero
    write_reg(REG_YLIM, 0);
    f = '{64'd1, 0, 64'd1 << 20, 64'd1 << 40, 64'd1 << 40}; send_face(f);
    random_faces(70);
    drain();

    write_reg(REG_KAPPA, 0);
    write_reg(REG_E, Q_MAX);
    random_faces(70);
    drain();

    write_reg(REG_YLIM, Q_MAX);                   // everything laminar
    random_faces(30);
    drain();

    write_reg(REG_KAPPA, KAPPA_RST);
    write_reg(REG_E, E_RST);
    write_reg(REG_YLIM, YLIM_RST);
    random_faces(150);
    drain();

    for (int ph = 0; ph < 3; ph++) begin
      write_reg(REG_KAPPA, rnd_mag(30, 44));
      write_reg(REG_E, rnd_mag(36, 48));
      write_reg(REG_YLIM, rnd_mag(36, 46));
      random_faces(40);
      drain();
    end

    // closing stretch with no stalls
    calm = 1;
    write_reg(REG_KAPPA, KAPPA_RST);
    write_reg(REG_E, E_RST);
    write_reg(REG_YLIM, YLIM_RST);
    random_faces(80);
    drain();
    repeat (100) @(posedge clk_i);

    if (sb.failures == 0 && sb.pending.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
